// File: rtl/cda_pkg.sv
// Shared types, codes and calendar tables for the date arithmetic block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cda_pkg;

  // Command codes
  localparam logic [2:0] CMD_LOAD         = 3'd0;
  localparam logic [2:0] CMD_ADD_DAYS     = 3'd1;
  localparam logic [2:0] CMD_ADD_MONTHS   = 3'd2;
  localparam logic [2:0] CMD_ADD_YEARS    = 3'd3;
  localparam logic [2:0] CMD_NEXT_WORKDAY = 3'd4;
  localparam logic [2:0] CMD_NEXT_SUNDAY  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LOAD  = 2'd1;
  localparam logic [1:0] ST_NO_REACH  = 2'd2;
  localparam logic [1:0] ST_PRE_EPOCH = 2'd3;

  // Calendar limits
  localparam logic [13:0] YEAR_MIN   = 14'd1;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] EPOCH_YEAR = 14'd1970;
  // Leap years before the epoch (477), plus one for the 1-based day of year,
  // less the weekday of the epoch (4)
  localparam logic [13:0] WEEK_BIAS  = 14'd474;

  // Multiplier constants: inverse of 25 mod 2^14 and its divisibility limit,
  // reciprocals of 100 (scale 2^19) and 7 (scale 2^16)
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] INV25_LIM = 14'd655;
  localparam logic [13:0] RECIP100  = 14'd5243;
  localparam logic [13:0] RECIP7    = 14'd9363;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP,
    S_SH0, S_SH1, S_SH2, S_SH3, S_SH4,
    S_WK0, S_WK1, S_WK2, S_WK3,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_LEAP, MUL_DIV100, MUL_MOD7
  } mul_op_t;

  typedef struct packed {
    logic       leap;
    logic [6:0] q100;
    logic [2:0] rem7;
  } mul_res_t;

  // Days before the first of a month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month; codes outside 1..12 read as 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                     r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
      default:                  r = 5'd31;
    endcase
    return r;
  endfunction

  // Day of year, 1-based
  function automatic logic [8:0] ordinal(input logic [3:0] m, input logic [4:0] d,
                                         input logic leap);
    logic [8:0] r;
    r = month_start(m) + {4'd0, d};
    if (m > 4'd2 && leap) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

endpackage

// File: rtl/cda_shared_mul.sv
// Shared constant multiplier: leap test, year/100 and remainder mod 7.
// Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_shared_mul (
  input  cda_pkg::mul_op_t  op,
  input  logic [13:0]       operand,
  output cda_pkg::mul_res_t res
);
  import cda_pkg::*;

  logic [13:0] coef;
  logic [27:0] prod;
  logic [11:0] q7;

  // Pick the constant for this use
  always_comb begin
    case (op)
      MUL_LEAP:   coef = INV25;
      MUL_DIV100: coef = RECIP100;
      MUL_MOD7:   coef = RECIP7;
      default:    coef = INV25;
    endcase
  end

  assign prod = {14'd0, operand} * {14'd0, coef};
  assign q7   = prod[27:16];

  // Divisible by 25 when the inverse product stays under the limit
  assign res.leap = (operand[1:0] == 2'd0) &&
                    (!(prod[13:0] <= INV25_LIM) || (operand[3:0] == 4'd0));
  assign res.q100 = prod[25:19];
  // operand - 7q = operand - 8q + q, which is exact in three bits
  assign res.rem7 = operand[2:0] + q7[2:0];

endmodule

// File: rtl/calendar_date_arithmetic.sv
// Top level of the Gregorian date arithmetic block: sequencer and date state.
// Depends on cda_pkg and cda_shared_mul.
`timescale 1ns / 1ps
//
// Holds one date (reset 2001-01-01). Each input transaction carries a command
// (load, add days, add months, add years, next workday, next Sunday) with an
// amount and load fields; each produces exactly one output transaction with
// the new date, its weekday and a status code.
// Both channels use valid/ready. in_ready is high only while the sequencer is
// idle, so a new command is taken only after the previous one has gone to the
// output register. The time until out_valid rises is set by the month walk
// (one month per cycle, up to twelve) and by the weekday evaluation, states
// S_WK0 to S_WK3 with three passes through the one shared multiplier.
// The result sits in an output register: the sequencer takes the next command
// while a result waits, and only holds in its last step if the previous
// result has not yet been taken. A stalled result stays stable.
// Reset is synchronous, active low: date back to 2001-01-01, output empty.
//
module calendar_date_arithmetic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic signed [10:0]  in_amount,
  input  logic [13:0]         in_load_year,
  input  logic [3:0]          in_load_month,
  input  logic [4:0]          in_load_day,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [13:0]         out_year_now,
  output logic [3:0]          out_month_now,
  output logic [4:0]          out_day_now,
  output logic [2:0]          out_weekday,
  output logic [1:0]          out_status
);
  import cda_pkg::*;

  state_t state_r, state_nxt;
  logic [13:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  d_r, d_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        pre_r, pre_nxt;

  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [10:0] amt_r, amt_nxt;
  logic [13:0]        ldy_r, ldy_nxt;
  logic [3:0]         ldm_r, ldm_nxt;
  logic [4:0]         ldd_r, ldd_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [2:0]         wd_r, wd_nxt;
  logic [13:0]        wy_r, wy_nxt;
  logic signed [11:0] doy_r, doy_nxt;
  logic [3:0]         mm_r, mm_nxt;
  logic signed [10:0] n_r, n_nxt;
  logic               lp_r, lp_nxt;
  logic               lpn_r, lpn_nxt;
  logic               lpp_r, lpp_nxt;
  logic [6:0]         q100_r, q100_nxt;
  logic [13:0]        v_r, v_nxt;
  logic [13:0]        oy_r, oy_nxt;
  logic [3:0]         om_r, om_nxt;
  logic [4:0]         od_r, od_nxt;
  logic [2:0]         owd_r, owd_nxt;
  logic [1:0]         ost_r, ost_nxt;

  mul_op_t     mop;
  logic [13:0] mopnd;
  mul_res_t    mres;

  cda_shared_mul u_mul (
    .op      (mop),
    .operand (mopnd),
    .res     (mres)
  );

  // Month arithmetic candidates
  logic signed [11:0] mt;
  logic               mon_ok;
  logic [13:0]        mny;
  logic [3:0]         mnm;
  // Year arithmetic candidate
  logic signed [15:0] yt;
  // Day shift lengths
  logic signed [11:0] len_here, len_next, len_prev;
  logic [4:0]         walk_len;
  logic [2:0]         w;

  always_comb begin
    mt  = $signed({8'd0, m_r}) + $signed({amt_r[10], amt_r});
    mon_ok = 1'b1;
    mny = y_r;
    mnm = m_r;
    if (mt >= 12'sd13 && mt <= 12'sd24) begin
      mny = y_r + 14'd1;
      mnm = 4'(mt - 12'sd12);
      mon_ok = (y_r < YEAR_MAX);
    end else if (mt >= -12'sd11 && mt <= 12'sd0) begin
      mny = y_r - 14'd1;
      mnm = 4'(mt + 12'sd12);
      mon_ok = (y_r > YEAR_MIN);
    end else if (mt < 12'sd1 || mt > 12'sd12) begin
      mon_ok = 1'b0;
    end else begin
      mnm = 4'(mt);
    end
  end

  assign yt       = $signed({2'd0, y_r}) + $signed({{5{amt_r[10]}}, amt_r});
  assign len_here = lp_r  ? 12'sd366 : 12'sd365;
  assign len_next = lpn_r ? 12'sd366 : 12'sd365;
  assign len_prev = lpp_r ? 12'sd366 : 12'sd365;
  assign walk_len = month_len(mm_r, lp_r);
  assign w        = mres.rem7;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    pre_nxt       = pre_r;
    cmd_nxt       = cmd_r;
    amt_nxt       = amt_r;
    ldy_nxt       = ldy_r;
    ldm_nxt       = ldm_r;
    ldd_nxt       = ldd_r;
    status_nxt    = status_r;
    wd_nxt        = wd_r;
    wy_nxt        = wy_r;
    doy_nxt       = doy_r;
    mm_nxt        = mm_r;
    n_nxt         = n_r;
    lp_nxt        = lp_r;
    lpn_nxt       = lpn_r;
    lpp_nxt       = lpp_r;
    q100_nxt      = q100_r;
    v_nxt         = v_r;
    oy_nxt        = oy_r;
    om_nxt        = om_r;
    od_nxt        = od_r;
    owd_nxt       = owd_r;
    ost_nxt       = ost_r;
    mop           = MUL_LEAP;
    mopnd         = y_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          amt_nxt    = in_amount;
          ldy_nxt    = in_load_year;
          ldm_nxt    = in_load_month;
          ldd_nxt    = in_load_day;
          status_nxt = ST_OK;
          wd_nxt     = 3'd0;
          pre_nxt    = 1'b0;
          state_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        state_nxt = S_WK0;
        case (cmd_r)
          CMD_LOAD: begin
            mopnd = ldy_r;
            if (ldy_r >= YEAR_MIN && ldy_r <= YEAR_MAX && ldm_r >= 4'd1 &&
                ldm_r <= 4'd12 && ldd_r >= 5'd1 &&
                ldd_r <= month_len(ldm_r, mres.leap)) begin
              y_nxt = ldy_r;
              m_nxt = ldm_r;
              d_nxt = ldd_r;
            end else begin
              status_nxt = ST_BAD_LOAD;
            end
          end
          CMD_ADD_DAYS: begin
            n_nxt     = amt_r;
            state_nxt = S_SH0;
          end
          CMD_ADD_MONTHS: begin
            if (mon_ok) begin
              y_nxt = mny;
              m_nxt = mnm;
              // Late days: back three, change month, forward three
              if (d_r > 5'd28) begin
                d_nxt     = d_r - 5'd3;
                n_nxt     = 11'sd3;
                state_nxt = S_SH0;
              end
            end else begin
              status_nxt = ST_NO_REACH;
            end
          end
          CMD_ADD_YEARS: begin
            mopnd = yt[13:0];
            if (yt >= 16'sd1 && yt <= 16'sd9999) begin
              y_nxt = yt[13:0];
              if (m_r == 4'd2 && d_r == 5'd29 && !mres.leap) begin
                m_nxt = 4'd3;
                d_nxt = 5'd1;
              end
            end else begin
              status_nxt = ST_NO_REACH;
            end
          end
          CMD_NEXT_WORKDAY, CMD_NEXT_SUNDAY: begin
            if (y_r < EPOCH_YEAR) begin
              status_nxt = ST_PRE_EPOCH;
              state_nxt  = S_OUT;
            end else begin
              pre_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // Day shift: leap flags of this, next and previous year
      S_SH0: begin
        mopnd     = y_r;
        lp_nxt    = mres.leap;
        doy_nxt   = $signed({3'd0, ordinal(m_r, d_r, mres.leap)}) +
                    $signed({n_r[10], n_r});
        state_nxt = S_SH1;
      end
      S_SH1: begin
        mopnd     = y_r + 14'd1;
        lpn_nxt   = mres.leap;
        state_nxt = S_SH2;
      end
      S_SH2: begin
        mopnd     = y_r - 14'd1;
        lpp_nxt   = mres.leap;
        state_nxt = S_SH3;
      end

      // Pick the target year or drop the command
      S_SH3: begin
        mm_nxt    = 4'd1;
        state_nxt = S_SH4;
        if (doy_r >= 12'sd1 && doy_r <= len_here) begin
          wy_nxt = y_r;
        end else if (doy_r > len_here && doy_r <= len_here + len_next &&
                     y_r < YEAR_MAX) begin
          wy_nxt  = y_r + 14'd1;
          doy_nxt = doy_r - len_here;
          lp_nxt  = lpn_r;
        end else if (doy_r < 12'sd1 && doy_r + len_prev >= 12'sd1 &&
                     y_r > YEAR_MIN) begin
          wy_nxt  = y_r - 14'd1;
          doy_nxt = doy_r + len_prev;
          lp_nxt  = lpp_r;
        end else begin
          status_nxt = ST_NO_REACH;
          state_nxt  = S_WK0;
        end
      end

      // Walk one month per cycle
      S_SH4: begin
        if (mm_r < 4'd12 && doy_r > $signed({7'd0, walk_len})) begin
          doy_nxt = doy_r - $signed({7'd0, walk_len});
          mm_nxt  = mm_r + 4'd1;
        end else begin
          y_nxt     = wy_r;
          m_nxt     = mm_r;
          d_nxt     = doy_r[4:0];
          state_nxt = S_WK0;
        end
      end

      // Weekday: leap flag of the current year
      S_WK0: begin
        mopnd  = y_r;
        lp_nxt = mres.leap;
        if (y_r < EPOCH_YEAR) begin
          if (status_r == ST_OK) begin
            status_nxt = ST_PRE_EPOCH;
          end
          wd_nxt    = 3'd0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_WK1;
        end
      end
      S_WK1: begin
        mop       = MUL_DIV100;
        mopnd     = y_r - 14'd1;
        q100_nxt  = mres.q100;
        state_nxt = S_WK2;
      end
      // Value congruent mod 7 to the biased day count since the epoch, kept modulo 2^14
      S_WK2: begin
        mopnd = y_r - 14'd1;
        v_nxt = y_r - EPOCH_YEAR + {2'd0, mopnd[13:2]} - {7'd0, q100_r} +
                {9'd0, q100_r[6:2]} + {5'd0, ordinal(m_r, d_r, lp_r)} - WEEK_BIAS;
        state_nxt = S_WK3;
      end
      S_WK3: begin
        mop    = MUL_MOD7;
        mopnd  = v_r;
        wd_nxt = w;
        if (pre_r) begin
          pre_nxt   = 1'b0;
          state_nxt = S_SH0;
          if (cmd_r == CMD_NEXT_SUNDAY) begin
            n_nxt = {8'd0, 3'(3'd7 - w)};
          end else if (w == 3'd5) begin
            n_nxt = 11'sd3;
          end else if (w == 3'd6) begin
            n_nxt = 11'sd2;
          end else begin
            n_nxt = 11'sd1;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          oy_nxt        = y_r;
          om_nxt        = m_r;
          od_nxt        = d_r;
          owd_nxt       = wd_r;
          ost_nxt       = status_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and date state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      y_r         <= 14'd2001;
      m_r         <= 4'd1;
      d_r         <= 5'd1;
      out_valid_r <= 1'b0;
      pre_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      y_r         <= y_nxt;
      m_r         <= m_nxt;
      d_r         <= d_nxt;
      out_valid_r <= out_valid_nxt;
      pre_r       <= pre_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    amt_r    <= amt_nxt;
    ldy_r    <= ldy_nxt;
    ldm_r    <= ldm_nxt;
    ldd_r    <= ldd_nxt;
    status_r <= status_nxt;
    wd_r     <= wd_nxt;
    wy_r     <= wy_nxt;
    doy_r    <= doy_nxt;
    mm_r     <= mm_nxt;
    n_r      <= n_nxt;
    lp_r     <= lp_nxt;
    lpn_r    <= lpn_nxt;
    lpp_r    <= lpp_nxt;
    q100_r   <= q100_nxt;
    v_r      <= v_nxt;
    oy_r     <= oy_nxt;
    om_r     <= om_nxt;
    od_r     <= od_nxt;
    owd_r    <= owd_nxt;
    ost_r    <= ost_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_year_now  = oy_r;
  assign out_month_now = om_r;
  assign out_day_now   = od_r;
  assign out_weekday   = owd_r;
  assign out_status    = ost_r;

endmodule

// File: rtl/cda_checker.sv
// Port-level checks for the date arithmetic block, bound to its top level.
// Depends on cda_pkg and calendar_date_arithmetic.
`timescale 1ns / 1ps

module cda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_year_now,
  input logic [3:0]  out_month_now,
  input logic [4:0]  out_day_now,
  input logic [2:0]  out_weekday,
  input logic [1:0]  out_status
);
  import cda_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year_now) &&
      $stable(out_day_now) && $stable(out_status))
    else $error("stalled result changed");

  // Busy after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // Always a calendar date with a real weekday
  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_now >= 4'd1 && out_month_now <= 4'd12 &&
      out_day_now >= 5'd1 && out_weekday <= 3'd6)
    else $error("malformed date");

  // Before the epoch no weekday and never plain ok
  a_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_year_now < EPOCH_YEAR |-> out_weekday == 3'd0 && out_status != ST_OK)
    else $error("weekday before epoch");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_year_now  (out_year_now),
  .out_month_now (out_month_now),
  .out_day_now   (out_day_now),
  .out_weekday   (out_weekday),
  .out_status    (out_status)
);

// File: test/calendar_date_arithmetic_tb.sv
// Self-checking testbench for calendar_date_arithmetic: directed and random commands,
// with a built-in calendar predictor and random stalls on both channels.
// Depends on cda_pkg and the calendar_date_arithmetic RTL.
`timescale 1ns / 1ps

module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [1:0]  status;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = CMD_LOAD;
  logic signed [10:0] in_amount = '0;
  logic [13:0] in_load_year = '0;
  logic [3:0] in_load_month = '0;
  logic [4:0] in_load_day = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [13:0] out_year_now;
  logic [3:0] out_month_now;
  logic [4:0] out_day_now;
  logic [2:0] out_weekday;
  logic [1:0] out_status;

  // predictor state: the date the block should hold
  int held_year = 2001;
  int held_month = 1;
  int held_day = 1;

  date_result_t expected_dates[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int hold_request = 0;
  bit calm = 1'b0;
  int status_hits[4] = '{0, 0, 0, 0};

  calendar_date_arithmetic dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_amount(in_amount),
    .in_load_year(in_load_year), .in_load_month(in_load_month),
    .in_load_day(in_load_day),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_year_now(out_year_now), .out_month_now(out_month_now),
    .out_day_now(out_day_now), .out_weekday(out_weekday),
    .out_status(out_status)
  );

  always #4 clk = ~clk;

  initial begin
    #20ms;
    $display("timeout: %0d results still outstanding", expected_dates.size());
    $display("** calendar_date_arithmetic: FAILED **");
    $finish;
  end

  // ---------------- calendar predictor ----------------
  function automatic bit cal_leap(input int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int cal_year_days(input int y);
    return cal_leap(y) ? 366 : 365;
  endfunction

  function automatic int cal_month_days(input int y, input int m);
    if (m == 2) return cal_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int cal_day_of_year(input int y, input int m, input int d);
    int r;
    r = d;
    for (int k = 1; k < m; k++) r += cal_month_days(y, k);
    return r;
  endfunction

  // Move a date by n days, at most into the adjacent year; 0 when out of reach
  function automatic bit cal_advance(inout int y, inout int m, inout int d, input int n);
    int yy, doy, here;
    yy = y;
    doy = cal_day_of_year(yy, m, d) + n;
    here = cal_year_days(yy);
    if (doy >= 1 && doy <= here) begin
    end else if (doy > here && doy <= here + cal_year_days(yy + 1)) begin
      doy -= here;
      yy++;
    end else if (doy < 1 && doy + cal_year_days(yy - 1) >= 1) begin
      doy += cal_year_days(yy - 1);
      yy--;
    end else begin
      return 1'b0;
    end
    if (yy < 1 || yy > 9999) return 1'b0;
    y = yy;
    m = 1;
    while (m < 12 && doy > cal_month_days(yy, m)) begin
      doy -= cal_month_days(yy, m);
      m++;
    end
    d = doy;
    return 1'b1;
  endfunction

  function automatic int cal_leaps_until(input int y);
    int p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  // Weekday from the 1970 epoch, which fell on a Thursday
  function automatic int cal_weekday(input int y, input int m, input int d);
    int lin;
    lin = (y - 1970) * 365 + cal_leaps_until(y) - cal_leaps_until(1970)
          + cal_day_of_year(y, m, d) - 1;
    return (4 + lin) % 7;
  endfunction

  // Apply one command to the held date and return the expected result
  function automatic date_result_t apply_command(input logic [2:0] cmd, input int amt,
                                                 input int ly, input int lm, input int ld);
    int y, m, d, t, ny, nm, w, stride;
    logic [1:0] st;
    bit late;
    date_result_t r;
    y = held_year;
    m = held_month;
    d = held_day;
    st = ST_OK;
    case (cmd)
      CMD_LOAD: begin
        if (ly < 1 || ly > 9999 || lm < 1 || lm > 12 || ld < 1 ||
            ld > cal_month_days(ly, lm)) st = ST_BAD_LOAD;
        else begin
          y = ly; m = lm; d = ld;
        end
      end
      CMD_ADD_DAYS: begin
        if (!cal_advance(y, m, d, amt)) st = ST_NO_REACH;
      end
      CMD_ADD_MONTHS: begin
        t = m + amt;
        ny = y;
        nm = t;
        if (t >= 13 && t <= 24) begin
          ny = y + 1; nm = t - 12;
        end else if (t >= -11 && t <= 0) begin
          ny = y - 1; nm = t + 12;
        end else if (t < 1 || t > 12) begin
          st = ST_NO_REACH;
        end
        if (st == ST_OK && (ny < 1 || ny > 9999)) st = ST_NO_REACH;
        if (st == ST_OK) begin
          // late days step back three, change month, then step forward three
          late = d > 28;
          if (late) d -= 3;
          y = ny;
          m = nm;
          if (late) void'(cal_advance(y, m, d, 3));
        end
      end
      CMD_ADD_YEARS: begin
        ny = y + amt;
        if (ny < 1 || ny > 9999) st = ST_NO_REACH;
        else begin
          if (m == 2 && d == 29 && !cal_leap(ny)) begin
            m = 3; d = 1;
          end
          y = ny;
        end
      end
      CMD_NEXT_WORKDAY, CMD_NEXT_SUNDAY: begin
        if (y < 1970) st = ST_PRE_EPOCH;
        else begin
          w = cal_weekday(y, m, d);
          if (cmd == CMD_NEXT_SUNDAY) stride = 7 - w;
          else stride = (w == 5) ? 3 : (w == 6) ? 2 : 1;
          if (!cal_advance(y, m, d, stride)) st = ST_NO_REACH;
        end
      end
      default: ;
    endcase
    if (st == ST_BAD_LOAD || st == ST_NO_REACH) begin
      y = held_year; m = held_month; d = held_day;
    end
    held_year = y;
    held_month = m;
    held_day = d;
    r.wday = '0;
    if (y >= 1970) r.wday = 3'(cal_weekday(y, m, d));
    else if (st == ST_OK) st = ST_PRE_EPOCH;
    r.year = 14'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.status = st;
    return r;
  endfunction

  // Append one expectation at the tail of the queue
  task automatic queue_expected(input date_result_t item);
    expected_dates = {expected_dates, item};
  endtask

  // ---------------- stimulus ----------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command and hold it until accepted, then predict its result
  task automatic send_command(input logic [2:0] cmd, input int amt,
                              input int ly = 0, input int lm = 0, input int ld = 0);
    bit taken;
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_amount <= amt[10:0];
    in_load_year <= ly[13:0];
    in_load_month <= lm[3:0];
    in_load_day <= ld[4:0];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    queue_expected(apply_command(cmd, $signed(amt[10:0]), ly[13:0], lm[3:0], ld[4:0]));
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_date(input int y, input int m, input int d);
    send_command(CMD_LOAD, 0, y, m, d);
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_loads();
    send_command(CMD_ADD_DAYS, 0);
    load_date(1, 1, 1);
    load_date(9999, 12, 31);
    load_date(2000, 2, 29);
    load_date(1900, 2, 29);
    load_date(0, 5, 5);
    load_date(16383, 15, 31);
    load_date(2021, 0, 10);
    load_date(2021, 4, 31);
    load_date(2021, 4, 0);
  endtask

  task automatic test_add_days();
    load_date(9999, 12, 31);
    send_command(CMD_ADD_DAYS, 1);
    load_date(2023, 12, 31);
    send_command(CMD_ADD_DAYS, 366);
    send_command(CMD_ADD_DAYS, -731);
    load_date(2024, 1, 1);
    send_command(CMD_ADD_DAYS, -366);
    load_date(1, 1, 1);
    send_command(CMD_ADD_DAYS, -1);
    send_command(CMD_ADD_DAYS, 1023);
    send_command(CMD_ADD_DAYS, -1023);
  endtask

  task automatic test_add_months();
    load_date(2023, 1, 31);
    send_command(CMD_ADD_MONTHS, 1);
    send_command(CMD_ADD_MONTHS, 22);
    send_command(CMD_ADD_MONTHS, -14);
    send_command(CMD_ADD_MONTHS, -1023);
    load_date(9999, 12, 30);
    send_command(CMD_ADD_MONTHS, 1);
  endtask

  task automatic test_add_years();
    load_date(2024, 2, 29);
    send_command(CMD_ADD_YEARS, 1);
    send_command(CMD_ADD_YEARS, -1023);
    send_command(CMD_ADD_YEARS, 1023);
    load_date(9999, 1, 1);
    send_command(CMD_ADD_YEARS, 1);
  endtask

  task automatic test_weekday_steps();
    load_date(1969, 12, 31);
    send_command(CMD_NEXT_WORKDAY, 0);
    load_date(2023, 12, 29);
    send_command(CMD_NEXT_WORKDAY, 0);
    send_command(CMD_NEXT_SUNDAY, 0);
    send_command(CMD_NEXT_SUNDAY, 0);
    load_date(9999, 12, 31);
    send_command(CMD_NEXT_SUNDAY, 0);
  endtask

  function automatic int pick_year();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1960, 2100);
    if (r < 93) return $urandom_range(1, 9999);
    return (r < 96) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
  endfunction

  function automatic int pick_amount(input int narrow);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2 * narrow) - narrow;
    if (r < 90) return $urandom_range(0, 800) - 400;
    return $urandom_range(0, 2046) - 1023;
  endfunction

  // Random command mix, mostly valid dates so the date walks far
  task automatic test_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) load_date(pick_year(), $urandom_range(1, 12), $urandom_range(1, 31));
      else if (r < 19) load_date($urandom_range(0, 16383), $urandom_range(0, 15),
                                 $urandom_range(0, 31));
      else if (r < 44) send_command(CMD_ADD_DAYS, pick_amount(40));
      else if (r < 64) send_command(CMD_ADD_MONTHS, pick_amount(30));
      else if (r < 74) send_command(CMD_ADD_YEARS, pick_amount(5));
      else if (r < 87) send_command(CMD_NEXT_WORKDAY, pick_amount(5));
      else send_command(CMD_NEXT_SUNDAY, pick_amount(5));
    end
    calm = 1'b0;
  endtask

  // Stall the result side for a long stretch while commands keep coming
  task automatic test_backpressure();
    hold_request = 250;
    for (int i = 0; i < 6; i++) send_command(CMD_ADD_DAYS, $urandom_range(0, 20) - 10);
    wait_drained();
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin : result_ready
    int stall_left;
    if (hold_request > 0) begin
      out_ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(negedge clk) begin
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d-%0d-%0d at %0t",
                   out_year_now, out_month_now, out_day_now, $realtime);
      end else begin
        want = expected_dates.pop_front();
        status_hits[want.status]++;
        if (out_year_now !== want.year || out_month_now !== want.month ||
            out_day_now !== want.day || out_weekday !== want.wday ||
            out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch %0d: expected %0d-%0d-%0d wd %0d st %0d, ",
                      "got %0d-%0d-%0d wd %0d st %0d"},
                     results_seen, want.year, want.month, want.day, want.wday, want.status,
                     out_year_now, out_month_now, out_day_now, out_weekday, out_status);
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm = 1'b1;
    test_loads();
    calm = 1'b0;
    test_add_days();
    test_add_months();
    test_add_years();
    test_weekday_steps();
    wait_drained();
    test_backpressure();
    test_random(1100);
    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d commands, %0d results; status ok/bad/reach/pre-1970: %0d/%0d/%0d/%0d",
             items_sent, results_seen, status_hits[0], status_hits[1], status_hits[2],
             status_hits[3]);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("** calendar_date_arithmetic: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_dates.size());
      $display("** calendar_date_arithmetic: FAILED **");
    end
    $finish;
  end

endmodule
